// File: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; modules include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define BPFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks an implication between two expressions on every rising edge.
`define BPFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/bpfa_pkg.sv
// Shared types, widths and codes of the bitmap page frame allocator.
// Depends on nothing.
package bpfa_pkg;

  localparam int BITMAP_WORDS_DEF = 1024;
  localparam int REGION_COUNT_DEF = 3;
  localparam int REGION_MAX       = 3;

  localparam int ADDR_W  = 48;
  localparam int FRAME_W = 36;
  localparam int PAGES_W = 17;
  localparam int CAP_W   = 18;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_REG_COUNT = 6;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MEMORY = 3'd1;
  localparam logic [2:0] ST_NULL      = 3'd2;
  localparam logic [2:0] ST_UNALIGNED = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  page_address;
    logic [2:0]         status;
    logic               high_usage;
    logic [PAGES_W-1:0] pages_in_use;
  } rsp_t;

  typedef struct packed {
    logic              map_hit;
    logic [CAP_W-1:0]  rem_next;
    logic [ADDR_W-1:0] addr;
    logic              look_hit;
    logic [CAP_W-1:0]  idx;
    logic [CAP_W-1:0]  acc_next;
  } region_res_t;

endpackage

// File: rtl/bpfa_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  output logic [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/bpfa_region_unit.sv
// Shared region arithmetic: index to address mapping and address to index lookup.
// Depends on bpfa_pkg.
module bpfa_region_unit (
  input  logic [bpfa_pkg::FRAME_W-1:0] base_i,
  input  logic [bpfa_pkg::PAGES_W-1:0] pages_i,
  input  logic [bpfa_pkg::CAP_W-1:0]   rem_i,
  input  logic [bpfa_pkg::FRAME_W-1:0] frame_i,
  output bpfa_pkg::region_res_t        res_o
);
  import bpfa_pkg::*;

  logic [FRAME_W-1:0] frame_sum;
  logic [FRAME_W:0]   region_end;
  logic [FRAME_W-1:0] frame_off;

  always_comb begin
    frame_sum  = base_i + FRAME_W'(rem_i);
    region_end = {1'b0, base_i} + (FRAME_W+1)'(pages_i);
    frame_off  = frame_i - base_i;
    res_o.map_hit  = rem_i < CAP_W'(pages_i);
    res_o.rem_next = rem_i - CAP_W'(pages_i);
    res_o.addr     = {frame_sum, {PAGE_SHIFT{1'b0}}};
    res_o.look_hit = (frame_i >= base_i) && ({1'b0, frame_i} < region_end);
    res_o.idx      = rem_i + CAP_W'(frame_off);
    res_o.acc_next = rem_i + CAP_W'(pages_i);
  end
endmodule

// File: rtl/bpfa_word_find.sv
// Finds the lowest free usable bit of one bitmap word, masking bits past capacity.
// Depends on bpfa_pkg.
module bpfa_word_find (
  input  logic [bpfa_pkg::WORD_BITS-1:0] word_i,
  input  logic [31:0]                    word_base_i,
  input  logic [bpfa_pkg::CAP_W-1:0]     cap_i,
  output logic                           found_o,
  output logic [5:0]                     bit_o
);
  import bpfa_pkg::*;

  logic [31:0]          valid;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;

  always_comb begin
    valid = 32'(cap_i) - word_base_i;
    if (valid >= 32'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = (WORD_BITS'(1) << valid[5:0]) - WORD_BITS'(1);
    end
    avail   = ~word_i & mask;
    found_o = |avail;
    bit_o   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        bit_o = 6'(b);
      end
    end
  end
endmodule

// File: rtl/bitmap_page_frame_allocator.sv
// Allocate checks the count against capacity, then reads and scans bitmap words from the hint
// and maps the found bit to an address over the regions; it ends early when the count is full or the scan runs out.
// Free checks for null and unaligned addresses, looks the frame up over the regions, then clears its page bit.
// One item at a time; the next item can be accepted while the result strobe is high.
// After reset the bitmap is cleared one word per cycle, with busy high until every word is cleared.
// The result strobe lasts one cycle and cannot be stalled; config is always ready.
module bitmap_page_frame_allocator #(
  parameter int BITMAP_WORDS = bpfa_pkg::BITMAP_WORDS_DEF,
  parameter int REGION_COUNT = bpfa_pkg::REGION_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bpfa_pkg::req_t                req_i,
  output logic                          done_o,
  output bpfa_pkg::rsp_t                rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpfa_pkg::FRAME_W-1:0]  cfg_data_i
);
  import bpfa_pkg::*;
  `include "assert_macros.svh"

  localparam int WW   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int IDXW = WW + 6;
  localparam int CAP_LIM = BITMAP_WORDS * WORD_BITS;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_ACHK = 9'b000000100,
    S_ARD  = 9'b000001000,
    S_AEV  = 9'b000010000,
    S_MAP  = 9'b000100000,
    S_FCHK = 9'b001000000,
    S_FLK  = 9'b010000000,
    S_FWR  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [FRAME_W-1:0] base_q [REGION_MAX];
  logic [PAGES_W-1:0] pages_q [REGION_MAX];
  logic [WW:0]        w_q, w_d;
  logic [1:0]         r_q, r_d;
  logic [CAP_W-1:0]   rem_q, rem_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [IDXW-1:0]    fidx_q, fidx_d;
  logic [IDXW-1:0]    hint_q, hint_d;
  logic [CAP_W-1:0]   count_q, count_d;
  logic [CAP_W-1:0]   cap_q, cap_sum;
  logic [WW-1:0]      clr_q, clr_d;
  req_t               req_q, req_d;
  rsp_t               rsp_q, rsp_d;
  logic               done_q, done_d;
  logic               fin, fin_hu;
  logic               ram_we;
  logic [WW-1:0]      ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic               find_found;
  logic [5:0]         find_bit;
  region_res_t        reg_res;
  logic [CAP_W+3:0]   use_scaled, cap_scaled;

  always_comb begin
    cap_sum = '0;
    for (int r = 0; r < REGION_COUNT; r++) begin
      cap_sum = cap_sum + CAP_W'(pages_q[r]);
    end
    if (32'(cap_sum) > 32'(CAP_LIM)) begin
      cap_sum = CAP_W'(CAP_LIM);
    end
  end

  bpfa_ram #(.WIDTH(WORD_BITS), .DEPTH(BITMAP_WORDS)) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  bpfa_word_find u_find (
    .word_i     (ram_rdata),
    .word_base_i(32'(w_q) << 6),
    .cap_i      (cap_q),
    .found_o    (find_found),
    .bit_o      (find_bit)
  );

  bpfa_region_unit u_region (
    .base_i (base_q[r_q]),
    .pages_i(pages_q[r_q]),
    .rem_i  (rem_q),
    .frame_i(frame_q),
    .res_o  (reg_res)
  );

  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    r_d       = r_q;
    rem_d     = rem_q;
    frame_d   = frame_q;
    fidx_d    = fidx_q;
    hint_d    = hint_q;
    count_d   = count_q;
    clr_d     = clr_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    fin       = 1'b0;
    fin_hu    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = w_q[WW-1:0];
    ram_wdata = '0;
    case (state_q)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + WW'(1);
        if (clr_q == WW'(BITMAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = (req_i.kind == KIND_FREE) ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        rsp_d = '0;
        if ((32'(count_q) + 32'd1) > 32'(cap_q)) begin
          rsp_d.status = ST_NO_MEMORY;
          fin = 1'b1;
        end else begin
          w_d     = {1'b0, hint_q[IDXW-1:6]};
          state_d = S_ARD;
        end
      end
      S_ARD: begin
        if ((32'(w_q) >= 32'(BITMAP_WORDS)) || ((32'(w_q) << 6) >= 32'(cap_q))) begin
          rsp_d.status = ST_NO_MEMORY;
          fin = 1'b1;
        end else begin
          state_d = S_AEV;
        end
      end
      S_AEV: begin
        if (find_found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << find_bit);
          hint_d    = {w_q[WW-1:0], find_bit};
          count_d   = count_q + CAP_W'(1);
          rem_d     = CAP_W'({w_q[WW-1:0], find_bit});
          r_d       = '0;
          state_d   = S_MAP;
        end else begin
          w_d     = w_q + (WW+1)'(1);
          state_d = S_ARD;
        end
      end
      S_MAP: begin
        if (reg_res.map_hit) begin
          rsp_d.page_address = reg_res.addr;
          fin    = 1'b1;
          fin_hu = 1'b1;
        end else if (r_q == 2'(REGION_COUNT - 1)) begin
          fin    = 1'b1;
          fin_hu = 1'b1;
        end else begin
          rem_d = reg_res.rem_next;
          r_d   = r_q + 2'd1;
        end
      end
      S_FCHK: begin
        rsp_d   = '0;
        frame_d = req_q.free_address[ADDR_W-1:PAGE_SHIFT];
        rem_d   = '0;
        r_d     = '0;
        if (req_q.free_address == '0) begin
          rsp_d.status = ST_NULL;
          fin = 1'b1;
        end else if (req_q.free_address[PAGE_SHIFT-1:0] != '0) begin
          rsp_d.status = ST_UNALIGNED;
          fin = 1'b1;
        end else begin
          state_d = S_FLK;
        end
      end
      S_FLK: begin
        if (reg_res.look_hit) begin
          if (reg_res.idx < cap_q) begin
            fidx_d  = IDXW'(reg_res.idx);
            w_d     = (WW+1)'(reg_res.idx >> 6);
            state_d = S_FWR;
          end else begin
            rsp_d.status = ST_OUTSIDE;
            fin = 1'b1;
          end
        end else if (r_q == 2'(REGION_COUNT - 1)) begin
          rsp_d.status = ST_OUTSIDE;
          fin = 1'b1;
        end else begin
          rem_d = reg_res.acc_next;
          r_d   = r_q + 2'd1;
        end
      end
      S_FWR: begin
        if (r_q == 2'd3) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fidx_q[5:0]);
          if (fidx_q < hint_q) begin
            hint_d = fidx_q;
          end
          if (count_q != '0) begin
            count_d = count_q - CAP_W'(1);
          end
          fin = 1'b1;
        end else begin
          r_d = 2'd3;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    use_scaled = {1'b0, count_d, 3'b0} + {3'b0, count_d, 1'b0};
    cap_scaled = {1'b0, cap_q, 3'b0} + (CAP_W+4)'(cap_q);
    if (fin) begin
      rsp_d.pages_in_use = count_d[PAGES_W-1:0];
      rsp_d.high_usage   = fin_hu && (use_scaled > cap_scaled);
      done_d  = 1'b1;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      hint_q  <= '0;
      count_q <= '0;
      cap_q   <= '0;
      done_q  <= 1'b0;
      r_q     <= '0;
      for (int r = 0; r < REGION_MAX; r++) begin
        base_q[r]  <= '0;
        pages_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      count_q <= count_d;
      cap_q   <= cap_sum;
      done_q  <= done_d;
      r_q     <= r_d;
      if (cfg_valid_i && (32'(cfg_index_i) < 32'(CFG_REG_COUNT))) begin
        if (cfg_index_i[0]) begin
          pages_q[cfg_index_i[2:1]] <= cfg_data_i[PAGES_W-1:0];
        end else begin
          base_q[cfg_index_i[2:1]] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    rem_q   <= rem_d;
    frame_q <= frame_d;
    fidx_q  <= fidx_d;
    req_q   <= req_d;
    rsp_q   <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

  `BPFA_ASSERT(a_state_onehot, $onehot(state_q), "State register is not one-hot.")
  `BPFA_ASSERT_IMP(a_done_idle, done_q, !busy, "Result strobe while the block is busy.")
  `BPFA_ASSERT_IMP(a_accept_busy, start && !busy, ##1 busy, "Accepted item did not make the block busy.")
endmodule
